/* design/hte_pkg.sv */
// Shared types and constants for the Huffman trie bit decoder.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package hte_pkg;

  // Node store and code sizing
  localparam int NODE_COUNT    = 512;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int USED_W        = $clog2(NODE_COUNT + 1);
  localparam int MAX_CODE_BITS = 32;
  localparam int LEN_W         = $clog2(MAX_CODE_BITS + 1);
  localparam int SYMBOL_BITS   = 8;
  localparam int COUNT_W       = 32;

  // Input field widths
  localparam int ENTRY_LEN_W  = 6;
  localparam int ENTRY_CODE_W = 32;
  localparam int DATA_W       = 8;
  localparam int DATA_CNT_W   = $clog2(DATA_W + 1);

  // Stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;
  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 2;

  // Command queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CODE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DECODE,
    CMD_CLEAR
  } cmd_kind_t;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_kind_t                kind;
    logic [SYMBOL_BITS-1:0]   sym;
    logic [LEN_W-1:0]         len;
    logic [MAX_CODE_BITS-1:0] code;   // first code bit in the MSB
    logic [DATA_W-1:0]        data;
  } cmd_t;

  // One node of the trie as kept in the node store
  typedef struct packed {
    logic [NODE_W-1:0]      left_child;
    logic [NODE_W-1:0]      right_child;
    logic [SYMBOL_BITS-1:0] symbol;
  } node_word_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_WALK,
    BK_DONE
  } back_state_t;

endpackage

/* design/huffman_trie_bit_decoder.sv */
// Huffman trie bit decoder: a load item adds one code to the trie one code bit per cycle,
// stopping early when the node store fills; a decode item walks the trie one data bit per
// cycle unless output backpressure stalls it, and at each leaf emits the symbol and returns
// to the root before the next bit, stopping early once the symbol count runs out. The node
// store has a single read port: each step reads the next node and acts on it the cycle after.
// A clear item resets the trie at once, as the root sits in registers and nodes are only
// ever read below the allocation count. Results leave through an output register, and a
// four-entry command queue lets input beats arrive while the walk runs. Output backpressure
// stalls the walk only while a second result is already waiting.
// Depends on hte_pkg, hte_front, hte_cmd_fifo and hte_back.
`timescale 1ns / 1ps

module huffman_trie_bit_decoder import hte_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data,  // symbols_to_decode
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,      // entry_symbol, entry_length, entry_code,
                                               // data_byte, zero pad
  input  logic [OPCODE_W-1:0]    s_tuser,      // opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,      // symbol_out
  output logic [STATUS_W-1:0]    m_tuser,      // status
  output logic                   m_tlast       // last_of_run
);

  logic    fifo_full;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  logic    pop_valid;
  cmd_t    pop_cmd;
  status_t out_status;
  logic [SYMBOL_BITS-1:0] out_symbol;

  // Classify input beats
  hte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .fifo_full(fifo_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Buffer commands between the two sides
  hte_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .pop_valid(pop_valid),
    .pop_cmd  (pop_cmd)
  );

  // Execute loads, decodes and clears
  hte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd_valid  (pop_valid),
    .cmd        (pop_cmd),
    .cmd_pop    (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_symbol (out_symbol),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = OUT_TDATA_W'(out_symbol);
  assign m_tuser = out_status;

endmodule

/* design/hte_front.sv */
// Front end: takes input beats, drops unused opcodes, clamps and aligns code entries.
// Depends on hte_pkg; feeds hte_cmd_fifo.
`timescale 1ns / 1ps

module hte_front import hte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // entry_symbol, entry_length, entry_code, data_byte
  input  logic [OPCODE_W-1:0]   s_tuser,   // opcode
  input  logic                  fifo_full,
  output logic                  push,
  output cmd_t                  push_cmd
);

  localparam int SYM_LSB  = 0;
  localparam int LEN_LSB  = SYM_LSB + SYMBOL_BITS;
  localparam int CODE_LSB = LEN_LSB + ENTRY_LEN_W;
  localparam int DATA_LSB = CODE_LSB + ENTRY_CODE_W;

  logic [ENTRY_LEN_W-1:0]   ent_len;
  logic [ENTRY_CODE_W-1:0]  ent_code;
  logic [LEN_W-1:0]         len_clamped;
  logic [MAX_CODE_BITS-1:0] code_ext;
  logic                     beat;
  logic                     beat_q;

  assign ent_len  = s_tdata[LEN_LSB +: ENTRY_LEN_W];
  assign ent_code = s_tdata[CODE_LSB +: ENTRY_CODE_W];
  assign s_tready = !fifo_full;
  assign beat     = s_tvalid && s_tready;

  // Clamp overlong codes and move the first code bit to the top
  assign len_clamped = (int'(ent_len) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                       : LEN_W'(ent_len);
  assign code_ext    = MAX_CODE_BITS'(ent_code);

  // Classify the beat; unused opcodes are taken and dropped
  always_comb begin
    push_cmd.sym  = s_tdata[SYM_LSB +: SYMBOL_BITS];
    push_cmd.len  = len_clamped;
    push_cmd.code = code_ext << (LEN_W'(MAX_CODE_BITS) - len_clamped);
    push_cmd.data = s_tdata[DATA_LSB +: DATA_W];
    push_cmd.kind = CMD_LOAD;
    push          = 1'b0;
    unique case (s_tuser)
      OP_LOAD: begin
        push_cmd.kind = CMD_LOAD;
        push          = beat;
      end
      OP_DECODE: begin
        push_cmd.kind = CMD_DECODE;
        push          = beat;
      end
      OP_CLEAR: begin
        push_cmd.kind = CMD_CLEAR;
        push          = beat;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Register each handshake so a check can confirm no beat was taken while the queue was full
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_q <= 1'b0;
    end else begin
      beat_q <= beat;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> beat)
    else $error("front pushed a command without an input beat");
  assert property (@(posedge clk) disable iff (rst) push |-> int'(push_cmd.len) <= MAX_CODE_BITS)
    else $error("code length not clamped");
  assert property (@(posedge clk) disable iff (rst) beat_q |-> $past(!fifo_full))
    else $error("beat taken while queue full");

endmodule

/* design/hte_cmd_fifo.sv */
// Short command queue between the front end and the back end.
// Depends on hte_pkg for the command type and depth.
`timescale 1ns / 1ps

module hte_cmd_fifo import hte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) int'(count) <= FIFO_DEPTH)
    else $error("queue occupancy out of range");
  assert property (@(posedge clk) disable iff (rst) (pop && !pop_valid) |=> count == '0 || $past(push))
    else $error("pop from empty queue changed occupancy");
  assert property (@(posedge clk) disable iff (rst)
                   (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");

endmodule

/* design/hte_back.sv */
// Back end: node store, trie loading walk, bit-serial decode walk and result staging.
// Depends on hte_pkg; pops commands from hte_cmd_fifo.
`timescale 1ns / 1ps

module hte_back import hte_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SYMBOL_BITS-1:0] out_symbol,
  output status_t                out_status,
  output logic                   out_last
);

  // Node store; the root lives in registers so a clear needs no sweep
  node_word_t node_mem [NODE_COUNT];
  node_word_t rdata;
  logic [NODE_W-1:0] rd_addr;
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  node_word_t        mem_wdata;

  back_state_t state, state_next;

  logic [COUNT_W-1:0] symbols_to_decode;
  logic [COUNT_W-1:0] symbols_left, symbols_left_next;
  logic [NODE_W-1:0]  root_left, root_left_next;
  logic [NODE_W-1:0]  root_right, root_right_next;
  logic [USED_W-1:0]  nodes_used, nodes_used_next;

  // Decode walk
  logic [NODE_W-1:0]     walk_node, walk_node_next;
  logic                  at_root, at_root_next;
  logic                  arrived, arrived_next;
  logic [DATA_W-1:0]     dec_bits, dec_bits_next;
  logic [DATA_CNT_W-1:0] dec_cnt, dec_cnt_next;

  // Load walk
  logic [NODE_W-1:0]        ld_node, ld_node_next;
  logic                     ld_fresh, ld_fresh_next;
  logic [LEN_W-1:0]         ld_cnt, ld_cnt_next;
  logic [MAX_CODE_BITS-1:0] ld_code, ld_code_next;
  logic [SYMBOL_BITS-1:0]   ld_sym, ld_sym_next;

  // Result staging: one pending result, then the output register
  logic                   pend_valid, pend_valid_next;
  logic [SYMBOL_BITS-1:0] pend_sym;
  status_t                pend_status;
  logic                   out_load;
  logic                   out_free;

  // Step decisions
  logic                   emit;
  logic [SYMBOL_BITS-1:0] emit_sym;
  status_t                emit_status;
  logic                   stall;
  logic [NODE_W-1:0]      walk_l, walk_r, child;
  logic                   leaf, more;
  node_word_t             ld_word;
  logic                   ld_root, ld_bit;
  logic [NODE_W-1:0]      slot;
  logic                   store_full;
  logic [NODE_W-1:0]      new_node;

  // Read and write the node store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= node_mem[rd_addr];
  end

  // Current node as seen by the decode walk
  assign walk_l     = at_root ? root_left  : rdata.left_child;
  assign walk_r     = at_root ? root_right : rdata.right_child;
  assign leaf       = arrived && (rdata.left_child == '0) && (rdata.right_child == '0);
  assign more       = (dec_cnt != '0) && (symbols_left != '0);
  assign child      = dec_bits[DATA_W-1] ? walk_r : walk_l;

  // Current node as seen by the load walk
  assign ld_root    = (ld_node == '0);
  assign ld_word    = ld_root  ? node_word_t'{left_child: root_left, right_child: root_right,
                                              symbol: '0}
                    : ld_fresh ? '0 : rdata;
  assign ld_bit     = ld_code[MAX_CODE_BITS-1];
  assign slot       = ld_bit ? ld_word.right_child : ld_word.left_child;
  assign store_full = (nodes_used == USED_W'(NODE_COUNT));
  assign new_node   = nodes_used[NODE_W-1:0];

  // Pick the result this cycle would produce
  always_comb begin
    emit        = 1'b0;
    emit_sym    = '0;
    emit_status = ST_OK;
    unique case (state)
      BK_WALK: begin
        if (leaf) begin
          emit     = 1'b1;
          emit_sym = rdata.symbol;
        end else if (more && child == '0) begin
          emit        = 1'b1;
          emit_status = ST_BAD_CODE;
        end
      end
      BK_LOAD: begin
        if (ld_cnt != '0 && slot == '0 && store_full) begin
          emit        = 1'b1;
          emit_status = ST_FULL;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_free = !m_tvalid || m_tready;
  assign stall    = (emit || state == BK_DONE) && pend_valid && !out_free;
  assign out_load = !stall && pend_valid && (emit || state == BK_DONE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_LOAD:   state_next = BK_LOAD;
            CMD_DECODE: state_next = BK_WALK;
            default:    state_next = BK_IDLE;
          endcase
        end
      end
      BK_LOAD: begin
        if (!stall && (ld_cnt == '0 || (slot == '0 && store_full))) begin
          state_next = BK_DONE;
        end
      end
      BK_WALK: begin
        if (!stall && !leaf && !more) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!stall) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    cmd_pop           = 1'b0;
    rd_addr           = walk_node;
    mem_we            = 1'b0;
    mem_waddr         = ld_node;
    mem_wdata         = '0;
    symbols_left_next = symbols_left;
    root_left_next    = root_left;
    root_right_next   = root_right;
    nodes_used_next   = nodes_used;
    walk_node_next    = walk_node;
    at_root_next      = at_root;
    arrived_next      = arrived;
    dec_bits_next     = dec_bits;
    dec_cnt_next      = dec_cnt;
    ld_node_next      = ld_node;
    ld_fresh_next     = ld_fresh;
    ld_cnt_next       = ld_cnt;
    ld_code_next      = ld_code;
    ld_sym_next       = ld_sym;
    unique case (state)
      BK_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_CLEAR: begin
              root_left_next    = '0;
              root_right_next   = '0;
              nodes_used_next   = USED_W'(1);
              walk_node_next    = '0;
              at_root_next      = 1'b1;
              arrived_next      = 1'b0;
              symbols_left_next = symbols_to_decode;
            end
            CMD_LOAD: begin
              ld_node_next  = '0;
              ld_fresh_next = 1'b0;
              ld_cnt_next   = cmd.len;
              ld_code_next  = cmd.code;
              ld_sym_next   = cmd.sym;
            end
            default: begin
              dec_bits_next = cmd.data;
              dec_cnt_next  = DATA_CNT_W'(DATA_W);
            end
          endcase
        end
      end
      BK_LOAD: begin
        if (!stall) begin
          if (ld_cnt == '0) begin
            // Mark the end node; a symbol on the root is never read
            mem_we    = !ld_root;
            mem_wdata = '{left_child: ld_word.left_child,
                          right_child: ld_word.right_child, symbol: ld_sym};
          end else if (slot != '0) begin
            // Follow an existing child
            rd_addr       = slot;
            ld_node_next  = slot;
            ld_fresh_next = 1'b0;
            ld_cnt_next   = ld_cnt - 1'b1;
            ld_code_next  = ld_code << 1;
          end else if (store_full) begin
            // Settle a node made by this load before stopping
            mem_we    = !ld_root && ld_fresh;
            mem_wdata = '0;
          end else begin
            // Create a child and link it from the current node
            if (ld_root) begin
              if (ld_bit) begin
                root_right_next = new_node;
              end else begin
                root_left_next = new_node;
              end
            end else begin
              mem_we    = 1'b1;
              mem_wdata = ld_word;
              if (ld_bit) begin
                mem_wdata.right_child = new_node;
              end else begin
                mem_wdata.left_child = new_node;
              end
            end
            ld_node_next    = new_node;
            ld_fresh_next   = 1'b1;
            nodes_used_next = nodes_used + 1'b1;
            ld_cnt_next     = ld_cnt - 1'b1;
            ld_code_next    = ld_code << 1;
          end
        end
      end
      BK_WALK: begin
        if (!stall) begin
          if (leaf) begin
            // Symbol found: count it and go back to the root
            symbols_left_next = symbols_left - 1'b1;
            walk_node_next    = '0;
            at_root_next      = 1'b1;
            arrived_next      = 1'b0;
          end else if (more) begin
            dec_bits_next = dec_bits << 1;
            dec_cnt_next  = dec_cnt - 1'b1;
            if (child == '0) begin
              walk_node_next = '0;
              at_root_next   = 1'b1;
              arrived_next   = 1'b0;
            end else begin
              rd_addr        = child;
              walk_node_next = child;
              at_root_next   = 1'b0;
              arrived_next   = 1'b1;
            end
          end else begin
            arrived_next = 1'b0;
          end
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Pending result holds until the next one or the end of the item
  always_comb begin
    pend_valid_next = pend_valid;
    if (!stall) begin
      if (emit) begin
        pend_valid_next = 1'b1;
      end else if (state == BK_DONE) begin
        pend_valid_next = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= BK_IDLE;
      symbols_to_decode <= '0;
      symbols_left      <= '0;
      root_left         <= '0;
      root_right        <= '0;
      nodes_used        <= USED_W'(1);
      walk_node         <= '0;
      at_root           <= 1'b1;
      arrived           <= 1'b0;
      pend_valid        <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      state        <= state_next;
      symbols_left <= symbols_left_next;
      root_left    <= root_left_next;
      root_right   <= root_right_next;
      nodes_used   <= nodes_used_next;
      walk_node    <= walk_node_next;
      at_root      <= at_root_next;
      arrived      <= arrived_next;
      pend_valid   <= pend_valid_next;
      if (cfg_wr_en) begin
        symbols_to_decode <= cfg_wr_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dec_bits <= dec_bits_next;
    dec_cnt  <= dec_cnt_next;
    ld_node  <= ld_node_next;
    ld_fresh <= ld_fresh_next;
    ld_cnt   <= ld_cnt_next;
    ld_code  <= ld_code_next;
    ld_sym   <= ld_sym_next;
    if (emit && !stall) begin
      pend_sym    <= emit_sym;
      pend_status <= emit_status;
    end
    if (out_load) begin
      out_symbol <= pend_sym;
      out_status <= pend_status;
      out_last   <= (state == BK_DONE);
    end
  end

  assert property (@(posedge clk) disable iff (rst) at_root |-> walk_node == '0)
    else $error("walk at root with nonzero node");
  assert property (@(posedge clk) disable iff (rst) arrived |-> !at_root)
    else $error("fresh arrival flagged at the root");
  assert property (@(posedge clk) disable iff (rst)
                   nodes_used != '0 && nodes_used <= USED_W'(NODE_COUNT))
    else $error("node count out of range");
  assert property (@(posedge clk) disable iff (rst)
                   mem_we |-> mem_waddr != '0 && USED_W'(mem_waddr) < nodes_used)
    else $error("write to an unallocated node");
  assert property (@(posedge clk) disable iff (rst) state == BK_IDLE |-> !pend_valid)
    else $error("result left pending after item end");

endmodule
